/* rtl/assert_macros.svh */
// Assertion macros for the RTL file that checks its own logic (the decoder top level).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RVD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define RVD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* rtl/rvd_pkg.sv */
// Package for the RV32IM decoder: operation enum, opcodes, control struct, op tables.
`default_nettype none

package rvd_pkg;

	typedef enum logic [5:0] {
		OP_LUI, OP_AUIPC, OP_JAL, OP_JALR,
		OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
		OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
		OP_SB, OP_SH, OP_SW,
		OP_ADDI, OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI,
		OP_SLLI, OP_SRLI, OP_SRAI,
		OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA, OP_OR, OP_AND,
		OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU, OP_DIV, OP_DIVU, OP_REM, OP_REMU,
		OP_FENCE, OP_ECALL, OP_EBREAK, OP_ILLEGAL
	} op_t;

	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_OP_IMM = 7'h13;
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_MISC   = 7'h0F;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;

	localparam logic [31:0] ECALL_WORD  = 32'h0000_0073;
	localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;

	localparam logic [2:0] F3_ZERO = 3'd0;
	localparam logic [2:0] F3_SL   = 3'd1;
	localparam logic [2:0] F3_SR   = 3'd5;

	localparam logic [6:0] F7_BASE   = 7'h00;
	localparam logic [6:0] F7_ALT    = 7'h20;
	localparam logic [6:0] F7_MULDIV = 7'h01;

	typedef struct packed {
		logic load;
		logic store;
		logic branch;
		logic writes_rd;
		logic uses_rs1;
		logic uses_rs2;
		logic rs2_in_ex;
	} ctrl_t;

	function automatic op_t branch_op(input logic [2:0] f3);
		op_t r;
		case (f3)
			3'd0: r = OP_BEQ;
			3'd1: r = OP_BNE;
			3'd4: r = OP_BLT;
			3'd5: r = OP_BGE;
			3'd6: r = OP_BLTU;
			3'd7: r = OP_BGEU;
			default: r = OP_ILLEGAL;
		endcase
		return r;
	endfunction

	function automatic op_t load_op(input logic [2:0] f3);
		op_t r;
		case (f3)
			3'd0: r = OP_LB;
			3'd1: r = OP_LH;
			3'd2: r = OP_LW;
			3'd4: r = OP_LBU;
			3'd5: r = OP_LHU;
			default: r = OP_ILLEGAL;
		endcase
		return r;
	endfunction

	function automatic op_t store_op(input logic [2:0] f3);
		op_t r;
		case (f3)
			3'd0: r = OP_SB;
			3'd1: r = OP_SH;
			3'd2: r = OP_SW;
			default: r = OP_ILLEGAL;
		endcase
		return r;
	endfunction

	function automatic op_t alui_op(input logic [2:0] f3);
		op_t r;
		case (f3)
			3'd0: r = OP_ADDI;
			3'd2: r = OP_SLTI;
			3'd3: r = OP_SLTIU;
			3'd4: r = OP_XORI;
			3'd6: r = OP_ORI;
			3'd7: r = OP_ANDI;
			default: r = OP_ILLEGAL;
		endcase
		return r;
	endfunction

	function automatic op_t alur_op(input logic [2:0] f3);
		op_t r;
		case (f3)
			3'd0: r = OP_ADD;
			3'd1: r = OP_SLL;
			3'd2: r = OP_SLT;
			3'd3: r = OP_SLTU;
			3'd4: r = OP_XOR;
			3'd5: r = OP_SRL;
			3'd6: r = OP_OR;
			3'd7: r = OP_AND;
			default: r = OP_ILLEGAL;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/rvd_decode.sv */
// Operation and immediate decode of one RV32IM instruction word.
`default_nettype none

module rvd_decode
	import rvd_pkg::*;
(
	input  wire logic [31:0] word,
	output op_t              op,
	output logic      [31:0] imm
);

	logic [6:0]  opc;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j, shamt;

	assign opc = word[6:0];
	assign f3  = word[14:12];
	assign f7  = word[31:25];

	assign imm_i = {{20{word[31]}}, word[31:20]};
	assign imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
	assign imm_b = {{20{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};
	assign imm_u = {word[31:12], 12'b0};
	assign imm_j = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};
	assign shamt = {27'b0, word[24:20]};

	always_comb begin
		op  = OP_ILLEGAL;
		imm = '0;
		case (opc)
			OPC_LUI: begin
				op  = OP_LUI;
				imm = imm_u;
			end
			OPC_AUIPC: begin
				op  = OP_AUIPC;
				imm = imm_u;
			end
			OPC_JAL: begin
				op  = OP_JAL;
				imm = imm_j;
			end
			OPC_JALR: begin
				if (f3 == F3_ZERO) begin
					op  = OP_JALR;
					imm = imm_i;
				end
			end
			OPC_BRANCH: begin
				op  = branch_op(f3);
				imm = imm_b;
			end
			OPC_LOAD: begin
				op  = load_op(f3);
				imm = imm_i;
			end
			OPC_STORE: begin
				op  = store_op(f3);
				imm = imm_s;
			end
			OPC_OP_IMM: begin
				imm = imm_i;
				if (f3 == F3_SL) begin
					if (f7 == F7_BASE) begin
						op  = OP_SLLI;
						imm = shamt;
					end
				end else if (f3 == F3_SR) begin
					if (f7 == F7_BASE) begin
						op  = OP_SRLI;
						imm = shamt;
					end else if (f7 == F7_ALT) begin
						op  = OP_SRAI;
						imm = shamt;
					end
				end else begin
					op = alui_op(f3);
				end
			end
			OPC_OP: begin
				if (f7 == F7_BASE) begin
					op = alur_op(f3);
				end else if (f7 == F7_ALT) begin
					if (f3 == F3_ZERO) begin
						op = OP_SUB;
					end else if (f3 == F3_SR) begin
						op = OP_SRA;
					end
				end else if (f7 == F7_MULDIV) begin
					op = op_t'(6'(OP_MUL) + {3'b000, f3});
				end
			end
			OPC_MISC: begin
				op = OP_FENCE;
			end
			OPC_SYSTEM: begin
				if (word == ECALL_WORD) begin
					op = OP_ECALL;
				end else if (word == EBREAK_WORD) begin
					op = OP_EBREAK;
				end
			end
			default: begin
				op = OP_ILLEGAL;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/rvd_ctrl.sv */
// Pipeline control flags derived from the decoded operation.
`default_nettype none

module rvd_ctrl
	import rvd_pkg::*;
(
	input  wire op_t   op,
	output ctrl_t      ctrl
);

	logic ld, st, br, rr, sys;

	assign ld  = (op >= OP_LB) && (op <= OP_LHU);
	assign st  = (op >= OP_SB) && (op <= OP_SW);
	assign br  = (op >= OP_BEQ) && (op <= OP_BGEU);
	assign rr  = (op >= OP_ADD) && (op <= OP_REMU);
	assign sys = (op == OP_FENCE) || (op == OP_ECALL) || (op == OP_EBREAK) ||
		(op == OP_ILLEGAL);

	always_comb begin
		ctrl.load      = ld;
		ctrl.store     = st;
		ctrl.branch    = br;
		ctrl.writes_rd = !(br || st || sys);
		ctrl.uses_rs1  = !(sys || (op == OP_LUI) || (op == OP_AUIPC) || (op == OP_JAL));
		ctrl.uses_rs2  = br || st || rr;
		ctrl.rs2_in_ex = br || rr;
	end

endmodule

`default_nettype wire

/* rtl/rv32im_instruction_decoder.sv */
// Top level: input word register, decode logic, result register with handshake.
// An accepted word is held in the input register, then in the result register.
// One word per cycle unless the output stalls; these registers are two stages.
// instr_stall rises only when both stages hold words and the result side stalls.
// Reset clears the stage valid flags only; payload registers are not reset.
`default_nettype none
`include "assert_macros.svh"

module rv32im_instruction_decoder
	import rvd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               instr_valid,
	output logic                    instr_stall,
	input  wire logic        [31:0] instr_word,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic             [5:0]  op_code,
	output logic             [4:0]  dest_reg,
	output logic             [4:0]  src1_reg,
	output logic             [4:0]  src2_reg,
	output logic signed      [31:0] immediate,
	output logic                    is_load_op,
	output logic                    is_store_op,
	output logic                    is_branch_op,
	output logic                    writes_dest,
	output logic                    reads_src1,
	output logic                    reads_src2,
	output logic                    src2_in_execute
);

	logic        valid_s1, valid_s2;
	logic [31:0] word_s1;
	op_t         dec_op;
	logic [31:0] dec_imm;
	ctrl_t       dec_ctrl;
	op_t         op_s2;
	logic [31:0] imm_s2;
	logic [14:0] regs_s2;
	ctrl_t       ctrl_s2;
	logic        adv;
	logic        take;

	assign adv         = valid_s1 && (!valid_s2 || !result_stall);
	assign instr_stall = valid_s1 && valid_s2 && result_stall;
	assign take        = instr_valid && !instr_stall;

	rvd_decode u_decode (
		.word (word_s1),
		.op   (dec_op),
		.imm  (dec_imm)
	);

	rvd_ctrl u_ctrl (
		.op   (dec_op),
		.ctrl (dec_ctrl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_s1 <= instr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2   <= dec_op;
			imm_s2  <= dec_imm;
			regs_s2 <= {word_s1[11:7], word_s1[19:15], word_s1[24:20]};
			ctrl_s2 <= dec_ctrl;
		end
	end

	assign result_valid    = valid_s2;
	assign op_code         = op_s2;
	assign dest_reg        = regs_s2[14:10];
	assign src1_reg        = regs_s2[9:5];
	assign src2_reg        = regs_s2[4:0];
	assign immediate       = imm_s2;
	assign is_load_op      = ctrl_s2.load;
	assign is_store_op     = ctrl_s2.store;
	assign is_branch_op    = ctrl_s2.branch;
	assign writes_dest     = ctrl_s2.writes_rd;
	assign reads_src1      = ctrl_s2.uses_rs1;
	assign reads_src2      = ctrl_s2.uses_rs2;
	assign src2_in_execute = ctrl_s2.rs2_in_ex;

	`RVD_ASSERT_IMP(a_illegal_no_regs, result_valid && (op_code == OP_ILLEGAL),
		!writes_dest && !reads_src1 && !reads_src2)
	`RVD_ASSERT_NXT(a_s1_held, valid_s1 && !adv, valid_s1 && $stable(word_s1))
	`RVD_ASSERT_NXT(a_s2_load, adv,
		result_valid && (dest_reg == $past(word_s1[11:7])) &&
		(src2_reg == $past(word_s1[24:20])))

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the RV32IM instruction decoder: directed and random words.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rvd_pkg::*;

	localparam int IDLE_PCT = 21;
	localparam int MAX_REPORTS = 10;
	localparam int SETTLE_CYCLES = 6;

	// reserved funct3 slots
	localparam logic [2:0] F3_BR_RSVD = 3'd3;
	localparam logic [2:0] F3_LD_RSVD = 3'd7;
	localparam logic [2:0] F3_ST_RSVD = 3'd4;

	localparam op_t BRANCH_BY_F3 [8] = '{OP_BEQ, OP_BNE, OP_ILLEGAL, OP_ILLEGAL,
		OP_BLT, OP_BGE, OP_BLTU, OP_BGEU};
	localparam op_t LOAD_BY_F3 [8] = '{OP_LB, OP_LH, OP_LW, OP_ILLEGAL,
		OP_LBU, OP_LHU, OP_ILLEGAL, OP_ILLEGAL};
	localparam op_t STORE_BY_F3 [8] = '{OP_SB, OP_SH, OP_SW, OP_ILLEGAL,
		OP_ILLEGAL, OP_ILLEGAL, OP_ILLEGAL, OP_ILLEGAL};
	localparam op_t ALUI_BY_F3 [8] = '{OP_ADDI, OP_ILLEGAL, OP_SLTI, OP_SLTIU,
		OP_XORI, OP_ILLEGAL, OP_ORI, OP_ANDI};
	localparam op_t ALUR_BY_F3 [8] = '{OP_ADD, OP_SLL, OP_SLT, OP_SLTU,
		OP_XOR, OP_SRL, OP_OR, OP_AND};
	localparam logic [6:0] OPCODES [11] = '{OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR,
		OPC_BRANCH, OPC_LOAD, OPC_STORE, OPC_OP_IMM, OPC_OP, OPC_MISC, OPC_SYSTEM};

	typedef struct {
		logic [31:0] word;
		op_t         op;
		logic [4:0]  rd, rs1, rs2;
		logic [31:0] imm;
		logic        load, store, branch, wr_rd, rd_rs1, rd_rs2, rs2_ex;
	} decode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic instr_valid = 1'b0;
	logic [31:0] instr_word = '0;
	logic result_stall = 1'b0;
	logic no_gaps = 1'b0;

	logic instr_stall;
	logic result_valid;
	logic [5:0] op_code;
	logic [4:0] dest_reg, src1_reg, src2_reg;
	logic signed [31:0] immediate;
	logic is_load_op, is_store_op, is_branch_op;
	logic writes_dest, reads_src1, reads_src2, src2_in_execute;

	decode_t expected_decodes [$];
	int fail_count = 0;

	rv32im_instruction_decoder uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.instr_valid    (instr_valid),
		.instr_stall    (instr_stall),
		.instr_word     (instr_word),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.op_code        (op_code),
		.dest_reg       (dest_reg),
		.src1_reg       (src1_reg),
		.src2_reg       (src2_reg),
		.immediate      (immediate),
		.is_load_op     (is_load_op),
		.is_store_op    (is_store_op),
		.is_branch_op   (is_branch_op),
		.writes_dest    (writes_dest),
		.reads_src1     (reads_src1),
		.reads_src2     (reads_src2),
		.src2_in_execute(src2_in_execute)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic decode_t decode_instr(input logic [31:0] w);
		decode_t d;
		logic [2:0] f3;
		logic [6:0] f7;
		logic [31:0] imm_i;
		f3 = w[14:12];
		f7 = w[31:25];
		imm_i = {{20{w[31]}}, w[31:20]};
		d.word = w;
		d.op = OP_ILLEGAL;
		d.imm = '0;
		d.rd = w[11:7];
		d.rs1 = w[19:15];
		d.rs2 = w[24:20];
		case (w[6:0])
			OPC_LUI: begin
				d.op = OP_LUI;
				d.imm = {w[31:12], 12'b0};
			end
			OPC_AUIPC: begin
				d.op = OP_AUIPC;
				d.imm = {w[31:12], 12'b0};
			end
			OPC_JAL: begin
				d.op = OP_JAL;
				d.imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
			end
			OPC_JALR: if (f3 == F3_ZERO) begin
				d.op = OP_JALR;
				d.imm = imm_i;
			end
			OPC_BRANCH: begin
				d.op = BRANCH_BY_F3[f3];
				d.imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
			end
			OPC_LOAD: begin
				d.op = LOAD_BY_F3[f3];
				d.imm = imm_i;
			end
			OPC_STORE: begin
				d.op = STORE_BY_F3[f3];
				d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
			end
			OPC_OP_IMM: begin
				d.op = ALUI_BY_F3[f3];
				d.imm = imm_i;
				if (f3 == F3_SL && f7 == F7_BASE)
					d.op = OP_SLLI;
				else if (f3 == F3_SR && f7 == F7_BASE)
					d.op = OP_SRLI;
				else if (f3 == F3_SR && f7 == F7_ALT)
					d.op = OP_SRAI;
				if (d.op inside {OP_SLLI, OP_SRLI, OP_SRAI})
					d.imm = {27'b0, w[24:20]};
			end
			OPC_OP: begin
				if (f7 == F7_BASE)
					d.op = ALUR_BY_F3[f3];
				else if (f7 == F7_ALT && f3 == F3_ZERO)
					d.op = OP_SUB;
				else if (f7 == F7_ALT && f3 == F3_SR)
					d.op = OP_SRA;
				else if (f7 == F7_MULDIV)
					d.op = op_t'(6'(OP_MUL) + {3'b000, f3});
			end
			OPC_MISC: d.op = OP_FENCE;
			OPC_SYSTEM: begin
				if (w == ECALL_WORD)
					d.op = OP_ECALL;
				else if (w == EBREAK_WORD)
					d.op = OP_EBREAK;
			end
			default: ;
		endcase
		d.load = d.op >= OP_LB && d.op <= OP_LHU;
		d.store = d.op >= OP_SB && d.op <= OP_SW;
		d.branch = d.op >= OP_BEQ && d.op <= OP_BGEU;
		d.wr_rd = !(d.branch || d.store ||
			d.op inside {OP_FENCE, OP_ECALL, OP_EBREAK, OP_ILLEGAL});
		d.rd_rs1 = !(d.op inside {OP_LUI, OP_AUIPC, OP_JAL, OP_FENCE, OP_ECALL,
			OP_EBREAK, OP_ILLEGAL});
		d.rd_rs2 = d.branch || d.store || (d.op >= OP_ADD && d.op <= OP_REMU);
		d.rs2_ex = d.rd_rs2 && !d.store;
		return d;
	endfunction

	function automatic logic [31:0] with_opcode(input logic [31:0] w, input logic [6:0] opc);
		return {w[31:7], opc};
	endfunction

	function automatic logic [31:0] set_fields(input logic [31:0] w, input logic [6:0] opc,
			input logic [2:0] f3, input logic [6:0] f7);
		return {f7, w[24:15], f3, w[11:7], opc};
	endfunction

	// legal_pct: share of well-formed words, the rest is raw noise or near misses
	function automatic logic [31:0] random_word(input int legal_pct);
		logic [31:0] w;
		logic [6:0] opc;
		logic [2:0] f3;
		logic [6:0] f7;
		w = $urandom();
		opc = OPCODES[$urandom_range(10)];
		f3 = w[14:12];
		f7 = w[31:25];
		if ($urandom_range(99) >= legal_pct)
			return ($urandom_range(1) != 0) ? w : with_opcode(w, opc);
		case (opc)
			OPC_JALR: f3 = F3_ZERO;
			OPC_BRANCH: while (BRANCH_BY_F3[f3] == OP_ILLEGAL) f3 = 3'($urandom_range(7));
			OPC_LOAD: while (LOAD_BY_F3[f3] == OP_ILLEGAL) f3 = 3'($urandom_range(7));
			OPC_STORE: while (STORE_BY_F3[f3] == OP_ILLEGAL) f3 = 3'($urandom_range(7));
			OPC_OP_IMM: begin
				if (f3 == F3_SL)
					f7 = F7_BASE;
				else if (f3 == F3_SR)
					f7 = ($urandom_range(1) != 0) ? F7_ALT : F7_BASE;
			end
			OPC_OP: begin
				f7 = ($urandom_range(1) != 0) ? F7_BASE : F7_MULDIV;
				if ($urandom_range(2) == 0) begin
					f7 = F7_ALT;
					f3 = ($urandom_range(1) != 0) ? F3_SR : F3_ZERO;
				end
			end
			OPC_SYSTEM: return ($urandom_range(1) != 0) ? EBREAK_WORD : ECALL_WORD;
			default: ;
		endcase
		return set_fields(w, opc, f3, f7);
	endfunction

	task automatic send_word(input logic [31:0] w);
		instr_valid <= 1'b1;
		instr_word <= w;
		@(posedge clk);
		while (instr_stall) @(posedge clk);
		expected_decodes.push_back(decode_instr(w));
		if (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
			instr_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
	endtask

	task automatic wait_for_results();
		instr_valid <= 1'b0;
		do @(posedge clk); while (expected_decodes.size() != 0);
	endtask

	task automatic test_directed_cases();
		send_word('0);
		send_word('1);
		send_word(with_opcode('1, OPC_LUI));
		send_word(with_opcode(32'h8000_0000, OPC_AUIPC));
		send_word(with_opcode('1, OPC_JAL));
		send_word(with_opcode(32'h8000_0000, OPC_JAL));
		send_word(with_opcode(32'h7FFF_FF80, OPC_JAL));
		send_word(set_fields('1, OPC_JALR, F3_ZERO, '1));
		send_word(set_fields('1, OPC_JALR, F3_SR, '1));
		send_word(set_fields('1, OPC_BRANCH, F3_BR_RSVD, '1));
		send_word(set_fields(32'h8000_0000, OPC_BRANCH, F3_ZERO, 7'h40));
		send_word(set_fields('1, OPC_LOAD, F3_LD_RSVD, '1));
		send_word(set_fields(32'h7FF0_0000, OPC_LOAD, F3_ZERO, 7'h3F));
		send_word(set_fields('1, OPC_STORE, F3_ST_RSVD, '1));
		send_word(set_fields(32'h8000_0000, OPC_STORE, F3_ZERO, 7'h40));
		send_word(set_fields('1, OPC_OP_IMM, F3_ZERO, '1));
		send_word(set_fields('1, OPC_OP_IMM, F3_SL, F7_BASE));
		send_word(set_fields('1, OPC_OP_IMM, F3_SL, F7_ALT));
		send_word(set_fields('1, OPC_OP_IMM, F3_SR, F7_ALT));
		send_word(set_fields('1, OPC_OP_IMM, F3_SR, '1));
		send_word(set_fields('1, OPC_OP, F3_ZERO, F7_ALT));
		send_word(set_fields('1, OPC_OP, F3_SL, F7_ALT));
		send_word(set_fields('1, OPC_OP, '1, F7_MULDIV));
		send_word(set_fields('1, OPC_OP, F3_ZERO, '1));
		send_word(with_opcode('1, OPC_MISC));
		send_word(ECALL_WORD);
		send_word(EBREAK_WORD);
		send_word(with_opcode('1, OPC_SYSTEM));
		send_word(ECALL_WORD ^ 32'h0000_0080);
		wait_for_results();
	endtask

	task automatic test_legal_stream();
		repeat (1000) send_word(random_word(80));
		wait_for_results();
	endtask

	task automatic test_back_to_back();
		no_gaps <= 1'b1;
		repeat (400) send_word(random_word(80));
		wait_for_results();
		no_gaps <= 1'b0;
	endtask

	task automatic test_malformed_words();
		repeat (600) send_word(random_word(10));
		wait_for_results();
	endtask

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%s", msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] word,
			input logic [31:0] want, input logic [31:0] got);
		if (want !== got)
			note_failure($sformatf("word %h %s: expected %h, got %h", word, name, want, got));
	endtask

	always @(posedge clk) begin
		result_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		decode_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_decodes.size() == 0) begin
				note_failure($sformatf("unexpected result word, op_code %0d", op_code));
			end else begin
				e = expected_decodes.pop_front();
				check_field("op_code", e.word, 32'(e.op), 32'(op_code));
				check_field("dest_reg", e.word, 32'(e.rd), 32'(dest_reg));
				check_field("src1_reg", e.word, 32'(e.rs1), 32'(src1_reg));
				check_field("src2_reg", e.word, 32'(e.rs2), 32'(src2_reg));
				check_field("immediate", e.word, e.imm, immediate);
				check_field("is_load_op", e.word, 32'(e.load), 32'(is_load_op));
				check_field("is_store_op", e.word, 32'(e.store), 32'(is_store_op));
				check_field("is_branch_op", e.word, 32'(e.branch), 32'(is_branch_op));
				check_field("writes_dest", e.word, 32'(e.wr_rd), 32'(writes_dest));
				check_field("reads_src1", e.word, 32'(e.rd_rs1), 32'(reads_src1));
				check_field("reads_src2", e.word, 32'(e.rd_rs2), 32'(reads_src2));
				check_field("src2_in_execute", e.word, 32'(e.rs2_ex),
					32'(src2_in_execute));
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_legal_stream();
		test_back_to_back();
		test_malformed_words();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_decodes.size() == 0)
			$display("rv32im_instruction_decoder regression: pass");
		else
			$display("rv32im_instruction_decoder regression: fail");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("rv32im_instruction_decoder regression: fail");
		$finish;
	end

endmodule

/* rv32im_instruction_decoder.f */
+incdir+rtl
rtl/rvd_pkg.sv
rtl/rvd_decode.sv
rtl/rvd_ctrl.sv
rtl/rv32im_instruction_decoder.sv
test/tb.sv
